// ===== rtl/dpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and codes for the derivation path parser: character
// classes, queue entry, result record and status codes.
// ----------------------------------------------------------------------------
package dpp_pkg;

    // character classes produced by the front end
    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_DIGIT = 3'd1;
    localparam logic [2:0] CLS_APOS  = 3'd2;
    localparam logic [2:0] CLS_SLASH = 3'd3;
    localparam logic [2:0] CLS_LTR_M = 3'd4;

    // status codes of the final result
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_PREFIX   = 3'd2;
    localparam logic [2:0] ST_LONG     = 3'd3;
    localparam logic [2:0] ST_BAD_CHAR = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_TOO_MANY = 3'd6;
    localparam logic [2:0] ST_TOO_FEW  = 3'd7;

    // result kinds
    localparam logic KIND_PART   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // classified character held in the queue
    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic       last;
    } item_t;

    // one result record
    typedef struct packed {
        logic        kind;
        logic [2:0]  part;
        logic [31:0] index;
        logic [2:0]  status;
        logic [5:0]  length;
        logic        last;
    } result_t;

endpackage

// ===== rtl/dpp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_front
// Accepts path characters and classifies each into digit, apostrophe,
// slash, letter m or other, with the digit value and end mark.
// ----------------------------------------------------------------------------
module dpp_front
    import dpp_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_char,
    output logic       q_wr_valid,
    input  logic       q_wr_ready,
    output item_t      q_wr_data
);

    // request goes straight into the queue when it has room
    assign q_wr_valid = s_valid;
    assign s_ready    = q_wr_ready;

    // character classification
    always_comb begin
        q_wr_data.last  = s_last_char;
        q_wr_data.digit = 4'(s_char_code - 8'h30);
        if (s_char_code >= 8'h30 && s_char_code <= 8'h39) begin
            q_wr_data.cls = CLS_DIGIT;
        end else if (s_char_code == 8'h27) begin
            q_wr_data.cls = CLS_APOS;
        end else if (s_char_code == 8'h2F) begin
            q_wr_data.cls = CLS_SLASH;
        end else if (s_char_code == 8'h6D) begin
            q_wr_data.cls = CLS_LTR_M;
        end else begin
            q_wr_data.cls = CLS_OTHER;
        end
    end

endmodule

// ===== rtl/dpp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_queue
// Four-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module dpp_queue
    import dpp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          push, pop;

    assign wr_ready = (count_reg != (PW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/dpp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_back
// Parser state machine: one classified character per cycle if results drain;
// builds part indexes, tracks the first error and drives the result register.
// ----------------------------------------------------------------------------
module dpp_back
    import dpp_pkg::*;
#(
    parameter int PATH_PARTS = 5,
    parameter int MAX_DIGITS = 10
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_rd_valid,
    output logic    q_rd_ready,
    input  item_t   q_rd_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    localparam logic [2:0] PH_M     = 3'd0;
    localparam logic [2:0] PH_SLASH = 3'd1;
    localparam logic [2:0] PH_NUM   = 3'd2;
    localparam logic [2:0] PH_HARD  = 3'd3;
    localparam logic [2:0] PH_FULL  = 3'd4;

    localparam logic [5:0] MIN_LEN  = 6'(2 * PATH_PARTS + 1);
    localparam logic [5:0] OK_LEN   = 6'(1 + 4 * PATH_PARTS);
    localparam logic [3:0] PARTS_W  = 4'(PATH_PARTS);
    localparam logic [3:0] DIGITS_W = 4'(MAX_DIGITS);

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  cc_reg, cc_next;
    logic [3:0]  dc_reg, dc_next;
    logic [30:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic        hard_reg, hard_next;
    logic [3:0]  pd_reg, pd_next;
    logic [2:0]  err_reg, err_next;

    logic        out_valid_reg, pend_valid_reg;
    result_t     out_reg, pend_reg;

    logic        pop, slot_free;
    logic        open, close_req;
    logic [34:0] prod;
    logic        r0_v;
    result_t     r0, r1;
    logic [2:0]  st;

    assign slot_free  = !out_valid_reg || m_ready;
    assign pop        = q_rd_valid && !pend_valid_reg && slot_free;
    assign q_rd_ready = pop;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    // times ten plus digit, shift and add
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + 35'(q_rd_data.digit);

    // next parser state and the results of this character
    always_comb begin
        phase_next = phase_reg;
        cc_next    = (cc_reg != 6'd63) ? cc_reg + 6'd1 : cc_reg;
        dc_next    = dc_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        hard_next  = hard_reg;
        pd_next    = pd_reg;
        err_next   = err_reg;
        open       = 1'b0;
        close_req  = 1'b0;
        r0_v       = 1'b0;
        r0         = '0;
        r1         = '0;
        st         = ST_OK;

        if (err_reg == ST_OK) begin
            case (phase_reg)
                PH_M: begin
                    if (q_rd_data.cls == CLS_LTR_M) phase_next = PH_SLASH;
                    else err_next = ST_PREFIX;
                end
                PH_SLASH: begin
                    if (q_rd_data.cls == CLS_SLASH) phase_next = PH_NUM;
                    else err_next = ST_PREFIX;
                end
                PH_NUM: begin
                    if (q_rd_data.cls == CLS_DIGIT) begin
                        if (dc_reg >= DIGITS_W) begin
                            err_next = ST_LONG;
                        end else begin
                            if (prod[34:31] != 4'd0) ovf_next = 1'b1;
                            acc_next = prod[30:0];
                            dc_next  = dc_reg + 4'd1;
                            open     = 1'b1;
                        end
                    end else if (q_rd_data.cls == CLS_APOS) begin
                        hard_next  = 1'b1;
                        phase_next = PH_HARD;
                        open       = 1'b1;
                    end else if (q_rd_data.cls == CLS_SLASH) begin
                        close_req = 1'b1;
                    end else begin
                        err_next = ST_BAD_CHAR;
                    end
                end
                PH_HARD: begin
                    if (q_rd_data.cls == CLS_SLASH) close_req = 1'b1;
                    else err_next = ST_BAD_CHAR;
                end
                default: begin
                    err_next = ST_TOO_MANY;
                end
            endcase
        end

        // an open part also closes at the end of the text
        if (q_rd_data.last && open) close_req = 1'b1;

        // part close
        if (close_req) begin
            if (ovf_next) begin
                err_next = ST_OVERFLOW;
            end else begin
                r0_v       = 1'b1;
                r0.kind    = KIND_PART;
                r0.part    = pd_reg[2:0];
                r0.index   = {hard_next, acc_next};
                pd_next    = pd_reg + 4'd1;
                acc_next   = '0;
                dc_next    = '0;
                ovf_next   = 1'b0;
                hard_next  = 1'b0;
                phase_next = (pd_next >= PARTS_W) ? PH_FULL : PH_NUM;
            end
        end

        // final status and return to the prefix state
        if (q_rd_data.last) begin
            if (err_next == ST_OK && phase_next != PH_FULL) err_next = ST_TOO_FEW;
            st        = (cc_next < MIN_LEN) ? ST_SHORT : err_next;
            r1.kind   = KIND_STATUS;
            r1.status = st;
            r1.length = (st == ST_OK) ? OK_LEN : 6'd0;
            r1.last   = 1'b1;
            phase_next = PH_M;
            cc_next    = '0;
            dc_next    = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            hard_next  = 1'b0;
            pd_next    = '0;
            err_next   = ST_OK;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_M;
            cc_reg    <= '0;
            dc_reg    <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            hard_reg  <= 1'b0;
            pd_reg    <= '0;
            err_reg   <= ST_OK;
        end else if (pop) begin
            phase_reg <= phase_next;
            cc_reg    <= cc_next;
            dc_reg    <= dc_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            hard_reg  <= hard_next;
            pd_reg    <= pd_next;
            err_reg   <= err_next;
        end
    end

    // result register with one pending slot for a second result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (slot_free) begin
            if (pend_valid_reg) begin
                out_reg        <= pend_reg;
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (pop && r0_v && q_rd_data.last) begin
                out_reg        <= r0;
                pend_reg       <= r1;
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b1;
            end else if (pop && r0_v) begin
                out_reg       <= r0;
                out_valid_reg <= 1'b1;
            end else if (pop && q_rd_data.last) begin
                out_reg       <= r1;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // checks
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a result in the output register");

    a_no_pop_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !pend_valid_reg)
        else $error("character taken while a second result still waits");

    a_part_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.kind == KIND_PART) |->
        (!out_reg.last && out_reg.status == ST_OK && out_reg.length == 6'd0
         && 4'(out_reg.part) < PARTS_W))
        else $error("malformed part result");

    a_ok_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.kind == KIND_STATUS) |->
        (out_reg.last && ((out_reg.status == ST_OK) == (out_reg.length == OK_LEN))))
        else $error("final status and byte count disagree");

endmodule

// ===== rtl/derivation_path_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// derivation_path_parser
// Parses a key derivation path text one character per request and returns
// one index per completed part and a final status with the byte count.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_       in         char_code[7:0], last_char
//  m_       out        result_kind, part_number[2:0], index_value[31:0],
//                      status[2:0], out_length[5:0], last_result
//
//  One character per cycle through the parser state machine while the output
//  register can take a result; a character that yields both a part index and
//  the final status holds the back end until the second result moves from the
//  pending slot into the output register. A four-entry queue lets input requests
//  keep arriving meanwhile and while m_ready is low. Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
module derivation_path_parser
    import dpp_pkg::*;
#(
    parameter int PATH_PARTS = 5,
    parameter int MAX_DIGITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [2:0]  m_part_number,
    output logic [31:0] m_index_value,
    output logic [2:0]  m_status,
    output logic [5:0]  m_out_length,
    output logic        m_last_result
);

    logic    q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    item_t   q_wr_data, q_rd_data;
    result_t res;

    // classify
    dpp_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_last_char (s_last_char),
        .q_wr_valid  (q_wr_valid),
        .q_wr_ready  (q_wr_ready),
        .q_wr_data   (q_wr_data)
    );

    // decoupling queue
    dpp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // parse and emit
    dpp_back #(
        .PATH_PARTS (PATH_PARTS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_data  (q_rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (res)
    );

    assign m_result_kind = res.kind;
    assign m_part_number = res.part;
    assign m_index_value = res.index;
    assign m_status      = res.status;
    assign m_out_length  = res.length;
    assign m_last_result = res.last;

endmodule
